// ===== rtl/core/assert_macros.svh =====
// Assertion macros shared by the hash core files.
// Both macros expect signals named clk and rst_n in the using module.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define B2S_ASSERT(label, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);
`define B2S_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);
`else
`define B2S_ASSERT(label, prop, msg)
`define B2S_ASSERT_NEXT(label, ante, cons, msg)
`endif
`endif

// ===== rtl/core/b2s_pkg.sv =====
package b2s_pkg;

    typedef logic [7:0][31:0] chain_t;
    typedef logic [3:0][31:0] row_t;

    typedef struct packed {
        logic start;
        logic last_blk;
    } eng_ctrl_t;

    typedef struct packed {
        logic busy;
        logic done;
    } eng_stat_t;

    localparam logic [31:0] IV [0:7] = '{
        32'h6A09E667, 32'hBB67AE85, 32'h3C6EF372, 32'hA54FF53A,
        32'h510E527F, 32'h9B05688C, 32'h1F83D9AB, 32'h5BE0CD19
    };

    localparam logic [31:0] PARAM_BASE = 32'h01010000;
    localparam logic [31:0] ALL_ONES   = 32'hFFFFFFFF;
    localparam logic [5:0]  LEN_RESET  = 6'd32;
    localparam logic [3:0]  LAST_RND   = 4'd9;

    // Message word schedule, one row per round.
    localparam logic [3:0] SIGMA [0:9][0:15] = '{
        '{ 4'd0,  4'd1,  4'd2,  4'd3,  4'd4,  4'd5,  4'd6,  4'd7,
           4'd8,  4'd9,  4'd10, 4'd11, 4'd12, 4'd13, 4'd14, 4'd15 },
        '{ 4'd14, 4'd10, 4'd4,  4'd8,  4'd9,  4'd15, 4'd13, 4'd6,
           4'd1,  4'd12, 4'd0,  4'd2,  4'd11, 4'd7,  4'd5,  4'd3 },
        '{ 4'd11, 4'd8,  4'd12, 4'd0,  4'd5,  4'd2,  4'd15, 4'd13,
           4'd10, 4'd14, 4'd3,  4'd6,  4'd7,  4'd1,  4'd9,  4'd4 },
        '{ 4'd7,  4'd9,  4'd3,  4'd1,  4'd13, 4'd12, 4'd11, 4'd14,
           4'd2,  4'd6,  4'd5,  4'd10, 4'd4,  4'd0,  4'd15, 4'd8 },
        '{ 4'd9,  4'd0,  4'd5,  4'd7,  4'd2,  4'd4,  4'd10, 4'd15,
           4'd14, 4'd1,  4'd11, 4'd12, 4'd6,  4'd8,  4'd3,  4'd13 },
        '{ 4'd2,  4'd12, 4'd6,  4'd10, 4'd0,  4'd11, 4'd8,  4'd3,
           4'd4,  4'd13, 4'd7,  4'd5,  4'd15, 4'd14, 4'd1,  4'd9 },
        '{ 4'd12, 4'd5,  4'd1,  4'd15, 4'd14, 4'd13, 4'd4,  4'd10,
           4'd0,  4'd7,  4'd6,  4'd3,  4'd9,  4'd2,  4'd8,  4'd11 },
        '{ 4'd13, 4'd11, 4'd7,  4'd14, 4'd12, 4'd1,  4'd3,  4'd9,
           4'd5,  4'd0,  4'd15, 4'd4,  4'd8,  4'd6,  4'd2,  4'd10 },
        '{ 4'd6,  4'd15, 4'd14, 4'd9,  4'd11, 4'd3,  4'd0,  4'd8,
           4'd12, 4'd2,  4'd13, 4'd7,  4'd1,  4'd4,  4'd10, 4'd5 },
        '{ 4'd10, 4'd2,  4'd8,  4'd4,  4'd7,  4'd6,  4'd1,  4'd5,
           4'd15, 4'd11, 4'd9,  4'd14, 4'd3,  4'd12, 4'd13, 4'd0 }
    };

    // Digest length clamped to 1..32 bytes.
    function automatic logic [5:0] eff_len(input logic [5:0] n);
        logic [5:0] r;
        if (n == 6'd0) r = 6'd1;
        else if (n > 6'd32) r = 6'd32;
        else r = n;
        return r;
    endfunction

    function automatic chain_t iv_chain(input logic [5:0] len);
        chain_t c;
        for (int i = 0; i < 8; i++) c[i] = IV[i];
        c[0] = IV[0] ^ PARAM_BASE ^ {26'd0, eff_len(len)};
        return c;
    endfunction

    // Keeps the low n bytes of a word; four or more keeps all.
    function automatic logic [31:0] byte_mask(input logic [2:0] n);
        logic [31:0] m;
        unique case (n)
            3'd0:    m = 32'h00000000;
            3'd1:    m = 32'h000000FF;
            3'd2:    m = 32'h0000FFFF;
            3'd3:    m = 32'h00FFFFFF;
            default: m = ALL_ONES;
        endcase
        return m;
    endfunction

    // Rotates a row of four words so that element p takes element p + k.
    function automatic row_t rot_row(input row_t r, input logic [1:0] k);
        row_t o;
        logic [1:0] idx;
        for (int p = 0; p < 4; p++) begin
            idx  = 2'(p) + k;
            o[p] = r[idx];
        end
        return o;
    endfunction

endpackage

// ===== rtl/core/b2s_stream_if.sv =====
interface b2s_msg_if;
    logic        valid;
    logic        ready;
    logic [31:0] data_word;
    logic [2:0]  byte_count;
    logic        last_of_message;

    modport source (output valid, data_word, byte_count, last_of_message, input ready);
    modport sink   (input valid, data_word, byte_count, last_of_message, output ready);
endinterface

interface b2s_dig_if;
    logic        valid;
    logic        ready;
    logic [31:0] digest_word;
    logic        last_word;

    modport source (output valid, digest_word, last_word, input ready);
    modport sink   (input valid, digest_word, last_word, output ready);
endinterface

// ===== rtl/core/b2s_g_half.sv =====
// One half of the mixing function: add, xor and rotate on four state words.
module b2s_g_half (
    input  logic [31:0] a,
    input  logic [31:0] b,
    input  logic [31:0] c,
    input  logic [31:0] d,
    input  logic [31:0] m,
    input  logic        second,
    output logic [31:0] a_new,
    output logic [31:0] b_new,
    output logic [31:0] c_new,
    output logic [31:0] d_new
);
    logic [31:0] dx;
    logic [31:0] bx;

    always_comb
    begin
        a_new = a + b + m;
        dx    = d ^ a_new;
        d_new = second ? {dx[7:0], dx[31:8]} : {dx[15:0], dx[31:16]};
        c_new = c + d_new;
        bx    = b ^ c_new;
        b_new = second ? {bx[6:0], bx[31:7]} : {bx[11:0], bx[31:12]};
    end
endmodule

// ===== rtl/core/b2s_engine.sv =====
`include "assert_macros.svh"

// Compression sequencer. The working state is held as four rows of four
// words; the mixing unit always works on element 0 of each row, and the
// rows are rotated between mixes so columns and diagonals line up there.
module b2s_engine (
    input  logic               clk,
    input  logic               rst_n,
    input  b2s_pkg::eng_ctrl_t ctrl,
    input  b2s_pkg::chain_t    chain,
    input  logic [63:0]        counter,
    input  logic [31:0]        msg_word,
    output logic [3:0]         msg_idx,
    output b2s_pkg::eng_stat_t stat,
    output b2s_pkg::chain_t    chain_new
);
    import b2s_pkg::*;

    localparam logic [1:0] ENG_IDLE = 2'd0;
    localparam logic [1:0] ENG_RUN  = 2'd1;
    localparam logic [1:0] ENG_DONE = 2'd2;

    logic [1:0]  state_reg, state_next;
    logic [3:0]  rnd_reg, rnd_next;
    logic [2:0]  g_reg, g_next;
    logic        h_reg, h_next;
    row_t        ra_reg, rb_reg, rc_reg, rd_reg;
    row_t        ra_next, rb_next, rc_next, rd_next;
    row_t        ra_w, rb_w, rc_w, rd_w;
    logic [31:0] a_new, b_new, c_new, d_new;

    assign msg_idx = SIGMA[rnd_reg][{g_reg, h_reg}];

    b2s_g_half u_g_half (
        .a      (ra_reg[0]),
        .b      (rb_reg[0]),
        .c      (rc_reg[0]),
        .d      (rd_reg[0]),
        .m      (msg_word),
        .second (h_reg),
        .a_new  (a_new),
        .b_new  (b_new),
        .c_new  (c_new),
        .d_new  (d_new)
    );

    always_comb
    begin
        ra_w = ra_reg;
        rb_w = rb_reg;
        rc_w = rc_reg;
        rd_w = rd_reg;
        ra_w[0] = a_new;
        rb_w[0] = b_new;
        rc_w[0] = c_new;
        rd_w[0] = d_new;

        state_next = state_reg;
        rnd_next   = rnd_reg;
        g_next     = g_reg;
        h_next     = h_reg;
        ra_next    = ra_reg;
        rb_next    = rb_reg;
        rc_next    = rc_reg;
        rd_next    = rd_reg;

        unique case (state_reg)
            ENG_IDLE:
            begin
                if (ctrl.start)
                begin
                    ra_next    = chain[3:0];
                    rb_next    = chain[7:4];
                    rc_next[0] = IV[0];
                    rc_next[1] = IV[1];
                    rc_next[2] = IV[2];
                    rc_next[3] = IV[3];
                    rd_next[0] = IV[4] ^ counter[31:0];
                    rd_next[1] = IV[5] ^ counter[63:32];
                    rd_next[2] = IV[6] ^ (ctrl.last_blk ? ALL_ONES : 32'd0);
                    rd_next[3] = IV[7];
                    rnd_next   = 4'd0;
                    g_next     = 3'd0;
                    h_next     = 1'b0;
                    state_next = ENG_RUN;
                end
            end
            ENG_RUN:
            begin
                h_next = ~h_reg;
                if (!h_reg)
                begin
                    ra_next = ra_w;
                    rb_next = rb_w;
                    rc_next = rc_w;
                    rd_next = rd_w;
                end
                else
                begin
                    g_next = g_reg + 3'd1;
                    if (g_reg == 3'd3)
                    begin
                        // Step to the next column and line up the diagonals.
                        ra_next = rot_row(ra_w, 2'd1);
                        rb_next = rot_row(rb_w, 2'd2);
                        rc_next = rot_row(rc_w, 2'd3);
                        rd_next = rd_w;
                    end
                    else if (g_reg == 3'd7)
                    begin
                        // Undo the diagonal alignment for the next round.
                        ra_next = rot_row(ra_w, 2'd1);
                        rb_next = rb_w;
                        rc_next = rot_row(rc_w, 2'd3);
                        rd_next = rot_row(rd_w, 2'd2);
                        if (rnd_reg == LAST_RND)
                        begin
                            rnd_next   = 4'd0;
                            state_next = ENG_DONE;
                        end
                        else
                        begin
                            rnd_next = rnd_reg + 4'd1;
                        end
                    end
                    else
                    begin
                        ra_next = rot_row(ra_w, 2'd1);
                        rb_next = rot_row(rb_w, 2'd1);
                        rc_next = rot_row(rc_w, 2'd1);
                        rd_next = rot_row(rd_w, 2'd1);
                    end
                end
            end
            ENG_DONE:
            begin
                state_next = ENG_IDLE;
            end
            default:
            begin
                state_next = ENG_IDLE;
            end
        endcase
    end

    always_comb
    begin
        for (int i = 0; i < 4; i++)
        begin
            chain_new[i]     = chain[i] ^ ra_reg[i] ^ rc_reg[i];
            chain_new[i + 4] = chain[i + 4] ^ rb_reg[i] ^ rd_reg[i];
        end
    end

    assign stat.busy = (state_reg != ENG_IDLE);
    assign stat.done = (state_reg == ENG_DONE);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ENG_IDLE;
            rnd_reg   <= 4'd0;
            g_reg     <= 3'd0;
            h_reg     <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            rnd_reg   <= rnd_next;
            g_reg     <= g_next;
            h_reg     <= h_next;
        end
    end

    always_ff @(posedge clk)
    begin
        ra_reg <= ra_next;
        rb_reg <= rb_next;
        rc_reg <= rc_next;
        rd_reg <= rd_next;
    end

    `B2S_ASSERT(a_rnd_range, rnd_reg <= LAST_RND, "round counter out of range")
    `B2S_ASSERT_NEXT(a_done_pulse, stat.done, !stat.done, "done held longer than one cycle")
    `B2S_ASSERT(a_start_idle, !ctrl.start || state_reg == ENG_IDLE, "start while engine busy")
endmodule

// ===== rtl/core/blake2s_stream_hash.sv =====
// Unkeyed BLAKE2s hash of a word stream.
// The msg channel carries one 32-bit little-endian message word per transfer.
// Every word counts four bytes except the one marked last_of_message, which
// carries byte_count valid bytes (0 to 4, larger values count as four).
// After the last word the digest channel delivers ceil(digest_length/4)
// words (length clamped to 1..32), with last_word set on the final one.
// The user must write digest_length through cfg_we/cfg_wdata only while the
// block is idle; the block does not enforce this. It resets to 32. A word
// is normally taken straight into the block buffer. A word that follows a
// full 64-byte block first waits for that block's compression, and the last
// word starts the final compression. A compression is ten rounds of eight
// mixes, each mix being two passes through the single shared mixing unit,
// plus start and fold steps. The digest follows, one digest word per cycle
// while digest.ready holds. msg.ready is low during compression and while
// the digest is delivered; a stall on the digest channel simply holds the
// current word. Reset clears the message state, so the next word starts anew.
module blake2s_stream_hash (
    input  logic      clk,
    input  logic      rst_n,
    input  logic      cfg_we,
    input  logic [5:0] cfg_wdata,
    b2s_msg_if.sink   msg,
    b2s_dig_if.source digest
);
    import b2s_pkg::*;

    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_COMP = 2'd1;
    localparam logic [1:0] ST_OUT  = 2'd2;

    logic [1:0]  state_reg, state_next;
    logic [5:0]  len_reg, len_next;
    chain_t      chain_reg, chain_next;
    logic [6:0]  fill_reg, fill_next;
    logic [63:0] count_reg, count_next;
    logic        started_reg, started_next;
    logic        last_blk_reg, last_blk_next;
    logic        start_reg, start_next;
    logic [31:0] pend_word_reg, pend_word_next;
    logic [2:0]  pend_n_reg, pend_n_next;
    logic        pend_last_reg, pend_last_next;
    logic [2:0]  k_reg, k_next;

    // Block buffer: one write port, one read port for the mixing unit.
    logic [31:0] blk_reg [16];
    logic        wr_en;
    logic [3:0]  wr_idx;
    logic [31:0] wr_data;

    logic [6:0]  fill_eff;
    logic [63:0] count_eff;
    logic [2:0]  n_in;
    logic        need_pre;
    logic [6:0]  fill_sum;

    logic [5:0]  len_eff;
    logic [6:0]  len_p3;
    logic [3:0]  n_words;
    logic [5:0]  rem;
    logic [31:0] out_mask;
    logic        out_last;

    eng_ctrl_t   eng_ctrl;
    eng_stat_t   eng_stat;
    chain_t      eng_chain;
    logic [3:0]  msg_idx;
    logic [31:0] msg_word;

    // A new message starts from an empty buffer and a zero counter.
    assign fill_eff  = started_reg ? fill_reg : 7'd0;
    assign count_eff = started_reg ? count_reg : 64'd0;

    // Only the last word may carry fewer than four bytes.
    assign n_in = !msg.last_of_message ? 3'd4 :
                  (msg.byte_count > 3'd4) ? 3'd4 : msg.byte_count;

    // A full block is compressed only once more data arrives behind it.
    assign need_pre = (n_in != 3'd0) && fill_eff[6];
    assign fill_sum = fill_eff + {4'd0, n_in};

    // Words past the buffered data read as zero, which pads the final block.
    assign msg_word = ({1'b0, msg_idx, 2'b00} < fill_reg) ? blk_reg[msg_idx] : 32'd0;

    assign eng_ctrl.start    = start_reg;
    assign eng_ctrl.last_blk = last_blk_reg;

    b2s_engine u_engine (
        .clk       (clk),
        .rst_n     (rst_n),
        .ctrl      (eng_ctrl),
        .chain     (chain_reg),
        .counter   (count_reg),
        .msg_word  (msg_word),
        .msg_idx   (msg_idx),
        .stat      (eng_stat),
        .chain_new (eng_chain)
    );

    // Digest word count and the byte mask of a partial final word.
    assign len_eff  = eff_len(len_reg);
    assign len_p3   = {1'b0, len_eff} + 7'd3;
    assign n_words  = len_p3[5:2];
    assign out_last = ({1'b0, k_reg} == (n_words - 4'd1));
    assign rem      = len_eff - {1'b0, k_reg, 2'b00};
    assign out_mask = (rem >= 6'd4) ? ALL_ONES : byte_mask(rem[2:0]);

    assign msg.ready          = (state_reg == ST_IDLE);
    assign digest.valid       = (state_reg == ST_OUT);
    assign digest.digest_word = chain_reg[k_reg] & out_mask;
    assign digest.last_word   = out_last;

    always_comb
    begin
        state_next     = state_reg;
        len_next       = cfg_we ? cfg_wdata : len_reg;
        chain_next     = chain_reg;
        fill_next      = fill_reg;
        count_next     = count_reg;
        started_next   = started_reg;
        last_blk_next  = last_blk_reg;
        start_next     = 1'b0;
        pend_word_next = pend_word_reg;
        pend_n_next    = pend_n_reg;
        pend_last_next = pend_last_reg;
        k_next         = k_reg;
        wr_en          = 1'b0;
        wr_idx         = 4'd0;
        wr_data        = 32'd0;

        unique case (state_reg)
            ST_IDLE:
            begin
                if (msg.valid)
                begin
                    started_next = !msg.last_of_message;
                    if (!started_reg)
                    begin
                        chain_next = iv_chain(len_reg);
                    end
                    if (need_pre)
                    begin
                        // Compress the full block first; the word waits.
                        count_next     = count_eff + 64'd64;
                        fill_next      = fill_eff;
                        pend_word_next = msg.data_word;
                        pend_n_next    = n_in;
                        pend_last_next = msg.last_of_message;
                        last_blk_next  = 1'b0;
                        start_next     = 1'b1;
                        state_next     = ST_COMP;
                    end
                    else
                    begin
                        wr_en     = (n_in != 3'd0);
                        wr_idx    = fill_eff[5:2];
                        wr_data   = msg.data_word & byte_mask(n_in);
                        fill_next = fill_sum;
                        if (msg.last_of_message)
                        begin
                            count_next    = count_eff + {57'd0, fill_sum};
                            last_blk_next = 1'b1;
                            start_next    = 1'b1;
                            state_next    = ST_COMP;
                        end
                        else
                        begin
                            count_next = count_eff;
                        end
                    end
                end
            end
            ST_COMP:
            begin
                if (eng_stat.done)
                begin
                    chain_next = eng_chain;
                    if (last_blk_reg)
                    begin
                        fill_next  = 7'd0;
                        k_next     = 3'd0;
                        state_next = ST_OUT;
                    end
                    else
                    begin
                        // The waiting word opens the next block.
                        wr_en     = 1'b1;
                        wr_idx    = 4'd0;
                        wr_data   = pend_word_reg & byte_mask(pend_n_reg);
                        fill_next = {4'd0, pend_n_reg};
                        if (pend_last_reg)
                        begin
                            count_next    = count_reg + {61'd0, pend_n_reg};
                            last_blk_next = 1'b1;
                            start_next    = 1'b1;
                        end
                        else
                        begin
                            state_next = ST_IDLE;
                        end
                    end
                end
            end
            ST_OUT:
            begin
                if (digest.ready)
                begin
                    if (out_last)
                    begin
                        state_next = ST_IDLE;
                    end
                    else
                    begin
                        k_next = k_reg + 3'd1;
                    end
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            len_reg       <= LEN_RESET;
            chain_reg     <= iv_chain(LEN_RESET);
            fill_reg      <= 7'd0;
            count_reg     <= 64'd0;
            started_reg   <= 1'b0;
            last_blk_reg  <= 1'b0;
            start_reg     <= 1'b0;
            k_reg         <= 3'd0;
        end
        else
        begin
            state_reg     <= state_next;
            len_reg       <= len_next;
            chain_reg     <= chain_next;
            fill_reg      <= fill_next;
            count_reg     <= count_next;
            started_reg   <= started_next;
            last_blk_reg  <= last_blk_next;
            start_reg     <= start_next;
            k_reg         <= k_next;
        end
    end

    always_ff @(posedge clk)
    begin
        pend_word_reg <= pend_word_next;
        pend_n_reg    <= pend_n_next;
        pend_last_reg <= pend_last_next;
        if (wr_en)
        begin
            blk_reg[wr_idx] <= wr_data;
        end
    end

    `B2S_ASSERT(a_no_overlap, !(msg.ready && digest.valid), "input taken during digest output")
    `B2S_ASSERT(a_fill_range, fill_reg <= 7'd64, "buffer fill beyond one block")
    `B2S_ASSERT(a_start_in_comp, !start_reg || state_reg == ST_COMP, "engine start outside compress")
    `B2S_ASSERT(a_busy_in_comp, !eng_stat.busy || state_reg == ST_COMP, "engine busy outside compress")
    `B2S_ASSERT_NEXT(a_idle_after_digest, digest.valid && digest.ready && digest.last_word, msg.ready, "not ready after digest")
endmodule
